// ===== src/pse_pkg.sv =====
// ----------------------------------------------------------------------------
// Postfix stack evaluator package
// Shared constants, status codes, state encoding and control structures.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int STACK_DEPTH_DEF = 16;

  localparam int SYM_W   = 8;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int OUT_W   = 40;

  localparam logic [SYM_W-1:0] SYM_ADD  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_SUB  = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_MUL  = 8'h2A;
  localparam logic [SYM_W-1:0] SYM_DIV  = 8'h2F;
  localparam logic [SYM_W-1:0] SYM_ZERO = 8'h30;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_UNDER   = 2'd1,
    ST_OVER    = 2'd2,
    ST_DIVZERO = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EXEC,
    S_DIV,
    S_WRITE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    push;
    logic    mem_rd;
    logic    exec_load;
    logic    div_start;
    logic    div_load;
    logic    pop_write;
    logic    emit;
    logic    err_note;
    status_t err_code;
  } cmd_t;

  typedef struct packed {
    logic is_op;
    logic is_div;
    logic lt2;
    logic full;
    logic rhs_zero;
    logic div_done;
    logic is_last;
    logic out_busy;
  } stat_t;

endpackage

// ===== src/pse_div.sv =====
// ----------------------------------------------------------------------------
// Postfix stack evaluator divider
// Signed 32-bit division truncating toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pse_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [pse_pkg::VALUE_W-1:0]    dividend,
  input  logic [pse_pkg::VALUE_W-1:0]    divisor,
  output logic                           done,
  output logic [pse_pkg::VALUE_W-1:0]    quotient
);

  localparam int W  = pse_pkg::VALUE_W;
  localparam int CW = $clog2(W);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dvs;
  logic          neg;
  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic [W-1:0]  mag_a;
  logic [W-1:0]  mag_b;

  assign mag_a   = dividend[W-1] ? (W'(0) - dividend) : dividend;
  assign mag_b   = divisor[W-1] ? (W'(0) - divisor) : divisor;
  assign shifted = {rem, quo[W-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= CW'(W - 1);
      rem <= '0;
      quo <= mag_a;
      dvs <= mag_b;
      neg <= dividend[W-1] ^ divisor[W-1];
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (!diff[W]) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= shifted[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? (W'(0) - quo) : quo;

endmodule

// ===== src/pse_datapath.sv =====
// ----------------------------------------------------------------------------
// Postfix stack evaluator datapath
// Value stack memory, top-of-stack register, arithmetic and result register.
// ----------------------------------------------------------------------------
module pse_datapath #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pse_pkg::cmd_t                 cmd,
  output pse_pkg::stat_t                stat,
  input  logic [pse_pkg::SYM_W-1:0]     in_symbol,
  input  logic                          in_last,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [pse_pkg::OUT_W-1:0]     out_data
);

  localparam int W  = pse_pkg::VALUE_W;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [W-1:0]                 mem [STACK_DEPTH];
  logic [W-1:0]                 rd_data;
  logic [CW-1:0]                count;
  logic [W-1:0]                 tos;
  logic [W-1:0]                 res;
  logic [pse_pkg::SYM_W-1:0]    sym;
  logic                         last;
  pse_pkg::status_t             err;
  logic [W-1:0]                 out_value;
  pse_pkg::status_t             out_status;
  logic [W-1:0]                 push_val;
  logic [W-1:0]                 alu;
  logic [CW-1:0]                below;
  logic [AW-1:0]                wr_addr;
  logic [W-1:0]                 wr_data;
  logic                         wr_en;
  logic                         div_done;
  logic [W-1:0]                 quotient;

  assign push_val = {{(W - pse_pkg::SYM_W){1'b0}}, sym} - W'(pse_pkg::SYM_ZERO);
  assign below    = count - CW'(2);

  always_comb begin
    case (sym)
      pse_pkg::SYM_ADD: alu = rd_data + tos;
      pse_pkg::SYM_SUB: alu = rd_data - tos;
      pse_pkg::SYM_MUL: alu = rd_data * tos;
      default:          alu = '0;
    endcase
  end

  always_comb begin
    wr_en   = cmd.push || cmd.pop_write;
    wr_addr = cmd.push ? count[AW-1:0] : below[AW-1:0];
    wr_data = cmd.push ? push_val : res;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.mem_rd) begin
      rd_data <= mem[below[AW-1:0]];
    end
  end

  pse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (rd_data),
    .divisor  (tos),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sym  <= in_symbol;
      last <= in_last;
    end
    if (cmd.exec_load) begin
      res <= alu;
    end else if (cmd.div_load) begin
      res <= quotient;
    end
    if (cmd.push) begin
      tos <= push_val;
    end else if (cmd.pop_write) begin
      tos <= res;
    end
    if (cmd.emit) begin
      out_value  <= (count != '0) ? tos : '0;
      out_status <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      err       <= pse_pkg::ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        count <= '0;
        err   <= pse_pkg::ST_OK;
      end else begin
        if (cmd.push) begin
          count <= count + CW'(1);
        end else if (cmd.pop_write) begin
          count <= count - CW'(1);
        end
        if (cmd.err_note && err == pse_pkg::ST_OK) begin
          err <= cmd.err_code;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.is_op    = (sym == pse_pkg::SYM_ADD) || (sym == pse_pkg::SYM_SUB) ||
                    (sym == pse_pkg::SYM_MUL) || (sym == pse_pkg::SYM_DIV);
    stat.is_div   = (sym == pse_pkg::SYM_DIV);
    stat.lt2      = (count < CW'(2));
    stat.full     = (count == CW'(STACK_DEPTH));
    stat.rhs_zero = (tos == '0);
    stat.div_done = div_done;
    stat.is_last  = last;
    stat.out_busy = out_valid && !out_ready;
  end

  assign out_data = {{(pse_pkg::OUT_W - W - pse_pkg::STAT_W){1'b0}}, out_status, out_value};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("Stack count exceeds the stack depth.");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (out_valid && count == '0 && err == pse_pkg::ST_OK))
    else $error("Result not presented or stack not emptied after the last item.");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> (!stat.rhs_zero && !stat.lt2))
    else $error("Division started with a zero divisor or too few operands.");

endmodule

// ===== src/pse_ctrl.sv =====
// ----------------------------------------------------------------------------
// Postfix stack evaluator controller
// Sequences decode, stack read, arithmetic, write-back and result hand-off.
// ----------------------------------------------------------------------------
module pse_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  pse_pkg::stat_t  stat,
  output pse_pkg::cmd_t   cmd
);

  pse_pkg::state_t state;
  pse_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pse_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      pse_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = pse_pkg::S_DECODE;
        end
      end
      pse_pkg::S_DECODE: begin
        if (!stat.is_op) begin
          if (stat.full) begin
            cmd.err_note = 1'b1;
            cmd.err_code = pse_pkg::ST_OVER;
          end else begin
            cmd.push = 1'b1;
          end
          state_next = pse_pkg::S_FINISH;
        end else if (stat.lt2) begin
          cmd.err_note = 1'b1;
          cmd.err_code = pse_pkg::ST_UNDER;
          state_next   = pse_pkg::S_FINISH;
        end else begin
          cmd.mem_rd = 1'b1;
          state_next = pse_pkg::S_EXEC;
        end
      end
      pse_pkg::S_EXEC: begin
        if (!stat.is_div) begin
          cmd.exec_load = 1'b1;
          state_next    = pse_pkg::S_WRITE;
        end else if (stat.rhs_zero) begin
          cmd.err_note = 1'b1;
          cmd.err_code = pse_pkg::ST_DIVZERO;
          state_next   = pse_pkg::S_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = pse_pkg::S_DIV;
        end
      end
      pse_pkg::S_DIV: begin
        if (stat.div_done) begin
          cmd.div_load = 1'b1;
          state_next   = pse_pkg::S_WRITE;
        end
      end
      pse_pkg::S_WRITE: begin
        cmd.pop_write = 1'b1;
        state_next    = pse_pkg::S_FINISH;
      end
      pse_pkg::S_FINISH: begin
        if (!stat.is_last) begin
          state_next = pse_pkg::S_IDLE;
        end else if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = pse_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pse_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/postfix_stack_evaluator_core.sv =====
// A push passes decode and finish before the next ready; + - * also pass exec
// and write, and a division waits in div on the one-bit-per-cycle divider
// (32 steps). An item marked last does not wait in finish when the output
// register is free; finish registers its result after the stack update.
// Synchronous active-high reset empties the stack, clears the sticky status
// and drops the output valid; the stack memory itself is not cleared.
// ----------------------------------------------------------------------------
// Postfix stack evaluator core
// Evaluates postfix expressions one character per item with a value stack.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_core #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // symbol[7:0]
  input  logic                       s_axis_tlast,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [pse_pkg::OUT_W-1:0]  m_axis_tdata    // value[31:0], status[33:32]
);

  pse_pkg::cmd_t  cmd;
  pse_pkg::stat_t stat;

  pse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pse_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_symbol (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata)
  );

endmodule
